/* design/cig_pkg.sv */
// ----------------------------------------------------------------------------
// cig_pkg: shared types and constants
// Sizes, register indexes, sequencer states and divider request type for the
// chunk interpolating gripper setpoint block.
// ----------------------------------------------------------------------------
`default_nettype none
package cig_pkg;

    // chunk capacity per bank
    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int DEPTH       = 2 * MAX_SAMPLES;

    // fixed field widths
    localparam int OPEN_W = 17;
    localparam int POS_W  = 18;
    localparam int DT_W   = 20;
    localparam int TIME_W = 32;
    localparam int PROD_W = OPEN_W + DT_W;

    // divider widths
    localparam int DQ_W   = 32;
    localparam int DR_W   = DT_W;
    localparam int DCNT_W = 6;

    // Q1.16 one
    localparam logic [OPEN_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [PROD_W:0]   HALF_Q16 = 38'd32768;

    // iteration counts
    localparam logic [DCNT_W-1:0] ITER_FULL = 6'd32;
    localparam logic [DCNT_W-1:0] ITER_FRAC = 6'd17;

    // register indexes
    typedef enum logic [1:0] {
        REG_SMOOTH_ALPHA = 2'd0,
        REG_MIN_POSITION = 2'd1,
        REG_MAX_POSITION = 2'd2,
        REG_SEGMENT_TIME = 2'd3
    } reg_index_t;

    // operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MNUM,
        ST_DIV,
        ST_MOPEN,
        ST_CHK,
        ST_SEG,
        ST_RD0,
        ST_RD1,
        ST_MUL1,
        ST_ACC,
        ST_INT,
        ST_RDLAST,
        ST_EMA,
        ST_EMA1,
        ST_EMA2,
        ST_OPOS,
        ST_OPOS2,
        ST_OUT
    } state_t;

    // divider start request
    typedef struct packed {
        logic              start;
        logic [DR_W-1:0]   rem_init;
        logic [DQ_W-1:0]   quo_init;
        logic [DR_W-1:0]   den;
        logic [DCNT_W-1:0] iters;
    } div_req_t;

endpackage
`default_nettype wire

/* design/chunk_interpolating_gripper_setpoint.sv */
// A sample item is taken while the sequencer is idle and gives no result. A tick's
// result is valid after divider runs for measured openness, segment search and
// interpolation plus sequencer, memory and multiply steps; a one-sample chunk, no
// chunk or no span skips some of these steps.
// Throughput: one item at a time; a stalled result holds the sequencer in ST_OUT.
// Reset (aresetn low, synchronous) clears control state and loads register defaults.
// ----------------------------------------------------------------------------
// chunk_interpolating_gripper_setpoint: chunk interpolating setpoint
// Double-buffered sample chunks, linear interpolation over time, adaptive
// smoothing and mapping of openness to a clamped joint position.
// ----------------------------------------------------------------------------
`default_nettype none
module chunk_interpolating_gripper_setpoint (
    input  wire                            aclk,
    input  wire                            aresetn,
    // config write
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [1:0]                     cfg_index,
    input  wire  [19:0]                    cfg_data,
    // input items
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_operation,
    input  wire  [31:0]                    s_time_us,
    input  wire  signed [17:0]             s_sample_value,
    input  wire                            s_last_sample,
    input  wire  [17:0]                    s_measured_position,
    // result items
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [17:0]                    m_position_command,
    output logic [16:0]                    m_measured_openness
);

    localparam int OW = cig_pkg::OPEN_W;
    localparam int PW = cig_pkg::POS_W;
    localparam int TW = cig_pkg::DT_W;
    localparam int XW = cig_pkg::PROD_W;
    localparam int CW = cig_pkg::CNT_W;
    localparam int AW = cig_pkg::ADDR_W;
    localparam int IW = cig_pkg::IDX_W;

    // configuration registers
    logic [OW-1:0] alpha_reg, alpha_next;
    logic [PW-1:0] minp_reg, minp_next;
    logic [PW-1:0] maxp_reg, maxp_next;
    logic [TW-1:0] segt_reg, segt_next;

    // control state
    cig_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] bank_cnt0_reg, bank_cnt0_next;
    logic [CW-1:0] bank_cnt1_reg, bank_cnt1_next;
    logic          active_reg, active_next;
    logic          chunk_valid_reg, chunk_valid_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic [OW-1:0] filt_reg, filt_next;
    logic          primed_reg, primed_next;
    logic          m_valid_reg, m_valid_next;

    // datapath registers
    logic [31:0]   now_reg, now_next;
    logic [PW-1:0] meas_reg, meas_next;
    logic [OW-1:0] mopen_reg, mopen_next;
    logic [IW-1:0] seg_reg, seg_next;
    logic [TW-1:0] frac_reg, frac_next;
    logic [OW-1:0] o0_reg, o0_next;
    logic [OW-1:0] o1_reg, o1_next;
    logic [OW-1:0] s_reg, s_next;
    logic [OW-1:0] g_reg, g_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [XW-1:0] prod_reg, prod_next;
    logic [PW-1:0] pos_stage_reg, pos_stage_next;
    logic [PW-1:0] m_pos_reg, m_pos_next;
    logic [OW-1:0] m_open_reg, m_open_next;

    // sample memory
    logic [OW-1:0] mem [cig_pkg::DEPTH];
    logic [OW-1:0] rd_data_reg;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [OW-1:0] wr_data;

    // shared multiplier operands
    logic [OW-1:0] mul_a;
    logic [TW-1:0] mul_b;

    // divider
    cig_pkg::div_req_t div_req;
    logic              div_busy;
    logic [31:0]       div_quo;
    logic [TW-1:0]     div_rem;

    // helpers
    logic [PW-1:0] span;
    logic          span_ok;
    logic [TW-1:0] dt_eff;
    logic [CW-1:0] n_act;
    logic          spare;
    logic [PW-1:0] pclamp, num;
    logic [34:0]   mdiv;
    logic [XW:0]   adiv, esum, psum;
    logic [31:0]   el;
    logic [OW-1:0] diff, lo, g;
    logic [19:0]   g5;
    logic [PW:0]   pos;
    logic [CW-1:0] load_inc;

    cig_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == cig_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_position_command  = m_pos_reg;
    assign m_measured_openness = m_open_reg;

    // shared multiplier
    assign prod_next = (state_reg == cig_pkg::ST_IDLE) ? prod_reg
                                                       : XW'(mul_a) * XW'(mul_b);

    // sequencer
    always_comb begin
        alpha_next       = alpha_reg;
        minp_next        = minp_reg;
        maxp_next        = maxp_reg;
        segt_next        = segt_reg;
        state_next       = state_reg;
        ret_next         = ret_reg;
        load_cnt_next    = load_cnt_reg;
        bank_cnt0_next   = bank_cnt0_reg;
        bank_cnt1_next   = bank_cnt1_reg;
        active_next      = active_reg;
        chunk_valid_next = chunk_valid_reg;
        stamp_next       = stamp_reg;
        filt_next        = filt_reg;
        primed_next      = primed_reg;
        m_valid_next     = m_valid_reg;
        now_next         = now_reg;
        meas_next        = meas_reg;
        mopen_next       = mopen_reg;
        seg_next         = seg_reg;
        frac_next        = frac_reg;
        o0_next          = o0_reg;
        o1_next          = o1_reg;
        s_next           = s_reg;
        g_next           = g_reg;
        acc_next         = acc_reg;
        pos_stage_next   = pos_stage_reg;
        m_pos_next       = m_pos_reg;
        m_open_next      = m_open_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        mul_a            = '0;
        mul_b            = '0;
        div_req          = '0;

        span     = maxp_reg - minp_reg;
        span_ok  = (maxp_reg > minp_reg);
        dt_eff   = (segt_reg == '0) ? TW'(1) : segt_reg;
        n_act    = active_reg ? bank_cnt1_reg : bank_cnt0_reg;
        spare    = ~active_reg;
        pclamp   = (meas_reg < minp_reg) ? minp_reg
                 : ((meas_reg > maxp_reg) ? maxp_reg : meas_reg);
        num      = pclamp - minp_reg;
        mdiv     = {1'b0, num, 16'd0} + 35'(span >> 1);
        adiv     = {1'b0, acc_reg} + {1'b0, prod_reg} + (XW + 1)'(dt_eff >> 1);
        esum     = {1'b0, acc_reg} + {1'b0, prod_reg} + cig_pkg::HALF_Q16;
        psum     = {1'b0, prod_reg} + cig_pkg::HALF_Q16;
        el       = now_reg - stamp_reg;
        diff     = (s_reg > filt_reg) ? (s_reg - filt_reg) : (filt_reg - s_reg);
        g5       = {1'b0, diff, 2'b00} + 20'(diff);
        lo       = (alpha_reg > cig_pkg::ONE_Q16) ? cig_pkg::ONE_Q16 : alpha_reg;
        g        = (g5 < 20'(lo)) ? lo
                 : ((g5 > 20'(cig_pkg::ONE_Q16)) ? cig_pkg::ONE_Q16 : g5[OW-1:0]);
        pos      = {1'b0, minp_reg} + (PW + 1)'(psum[XW:16]);
        load_inc = load_cnt_reg + 1'b1;

        // config writes
        if (cfg_valid) begin
            case (cig_pkg::reg_index_t'(cfg_index))
                cig_pkg::REG_SMOOTH_ALPHA: alpha_next = cfg_data[OW-1:0];
                cig_pkg::REG_MIN_POSITION: minp_next  = cfg_data[PW-1:0];
                cig_pkg::REG_MAX_POSITION: maxp_next  = cfg_data[PW-1:0];
                cig_pkg::REG_SEGMENT_TIME: segt_next  = cfg_data;
                default: ;
            endcase
        end

        // output handshake
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cig_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (cig_pkg::op_t'(s_operation) == cig_pkg::OP_LOAD) begin
                        // sample load into spare bank
                        if (load_cnt_reg < CW'(cig_pkg::MAX_SAMPLES)) begin
                            wr_en   = 1'b1;
                            wr_addr = {spare, load_cnt_reg[IW-1:0]};
                            if (s_sample_value[17]) begin
                                wr_data = '0;
                            end else if (s_sample_value[16:0] > cig_pkg::ONE_Q16) begin
                                wr_data = cig_pkg::ONE_Q16;
                            end else begin
                                wr_data = s_sample_value[16:0];
                            end
                            load_cnt_next = load_inc;
                        end
                        if (s_last_sample) begin
                            if (spare) begin
                                bank_cnt1_next = wr_en ? load_inc : load_cnt_reg;
                            end else begin
                                bank_cnt0_next = wr_en ? load_inc : load_cnt_reg;
                            end
                            active_next      = spare;
                            chunk_valid_next = 1'b1;
                            stamp_next       = s_time_us;
                            load_cnt_next    = '0;
                        end
                    end else begin
                        now_next   = s_time_us;
                        meas_next  = s_measured_position;
                        state_next = cig_pkg::ST_MNUM;
                    end
                end
            end
            // openness of measured position
            cig_pkg::ST_MNUM: begin
                if (!span_ok) begin
                    mopen_next = cig_pkg::ONE_Q16;
                    state_next = cig_pkg::ST_CHK;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = TW'(mdiv[34:17]);
                    div_req.quo_init = {mdiv[16:0], 15'd0};
                    div_req.den      = TW'(span);
                    div_req.iters    = cig_pkg::ITER_FRAC;
                    ret_next         = cig_pkg::ST_MOPEN;
                    state_next       = cig_pkg::ST_DIV;
                end
            end
            cig_pkg::ST_DIV: begin
                if (!div_busy) begin
                    state_next = ret_reg;
                end
            end
            cig_pkg::ST_MOPEN: begin
                if (div_quo[17:0] > 18'(cig_pkg::ONE_Q16)) begin
                    mopen_next = '0;
                end else begin
                    mopen_next = cig_pkg::ONE_Q16 - div_quo[OW-1:0];
                end
                state_next = cig_pkg::ST_CHK;
            end
            // two or more samples: start segment search; one sample: read it; none: go to output
            cig_pkg::ST_CHK: begin
                if (chunk_valid_reg && (n_act != '0)) begin
                    if (n_act == CW'(1)) begin
                        rd_en      = 1'b1;
                        rd_addr    = {active_reg, IW'(0)};
                        state_next = cig_pkg::ST_RDLAST;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.quo_init = el[31] ? 32'd0 : el;
                        div_req.den      = dt_eff;
                        div_req.iters    = cig_pkg::ITER_FULL;
                        ret_next         = cig_pkg::ST_SEG;
                        state_next       = cig_pkg::ST_DIV;
                    end
                end else begin
                    if (!primed_reg) begin
                        filt_next   = mopen_reg;
                        primed_next = 1'b1;
                    end
                    state_next = cig_pkg::ST_OPOS;
                end
            end
            cig_pkg::ST_SEG: begin
                frac_next = div_rem;
                seg_next  = div_quo[IW-1:0];
                rd_en     = 1'b1;
                if (div_quo >= 32'(n_act - 1'b1)) begin
                    rd_addr    = {active_reg, IW'(n_act - 1'b1)};
                    state_next = cig_pkg::ST_RDLAST;
                end else begin
                    rd_addr    = {active_reg, div_quo[IW-1:0]};
                    state_next = cig_pkg::ST_RD0;
                end
            end
            cig_pkg::ST_RD0: begin
                o0_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = {active_reg, IW'(seg_reg + 1'b1)};
                state_next = cig_pkg::ST_RD1;
            end
            // o0 * (dt - frac)
            cig_pkg::ST_RD1: begin
                o1_next    = rd_data_reg;
                mul_a      = o0_reg;
                mul_b      = dt_eff - frac_reg;
                state_next = cig_pkg::ST_MUL1;
            end
            // o1 * frac
            cig_pkg::ST_MUL1: begin
                acc_next   = prod_reg;
                mul_a      = o1_reg;
                mul_b      = frac_reg;
                state_next = cig_pkg::ST_ACC;
            end
            cig_pkg::ST_ACC: begin
                div_req.start    = 1'b1;
                div_req.rem_init = adiv[36:17];
                div_req.quo_init = {adiv[16:0], 15'd0};
                div_req.den      = dt_eff;
                div_req.iters    = cig_pkg::ITER_FRAC;
                ret_next         = cig_pkg::ST_INT;
                state_next       = cig_pkg::ST_DIV;
            end
            cig_pkg::ST_INT: begin
                s_next     = div_quo[OW-1:0];
                state_next = cig_pkg::ST_EMA;
            end
            cig_pkg::ST_RDLAST: begin
                s_next     = rd_data_reg;
                state_next = cig_pkg::ST_EMA;
            end
            // adaptive gain, g * s; an unprimed filter is seeded with s instead
            cig_pkg::ST_EMA: begin
                if (!primed_reg) begin
                    filt_next   = s_reg;
                    primed_next = 1'b1;
                    state_next  = cig_pkg::ST_OPOS;
                end else begin
                    g_next     = g;
                    mul_a      = g;
                    mul_b      = TW'(s_reg);
                    state_next = cig_pkg::ST_EMA1;
                end
            end
            // (1 - g) * f
            cig_pkg::ST_EMA1: begin
                acc_next   = prod_reg;
                mul_a      = cig_pkg::ONE_Q16 - g_reg;
                mul_b      = TW'(filt_reg);
                state_next = cig_pkg::ST_EMA2;
            end
            cig_pkg::ST_EMA2: begin
                filt_next  = esum[32:16];
                state_next = cig_pkg::ST_OPOS;
            end
            // openness to position
            cig_pkg::ST_OPOS: begin
                mul_a      = cig_pkg::ONE_Q16 - filt_reg;
                mul_b      = span_ok ? TW'(span) : '0;
                state_next = cig_pkg::ST_OPOS2;
            end
            // clamp into the staging register, the visible one may still be held
            cig_pkg::ST_OPOS2: begin
                if (pos < {1'b0, minp_reg}) begin
                    pos_stage_next = minp_reg;
                end else if (pos > {1'b0, maxp_reg}) begin
                    pos_stage_next = maxp_reg;
                end else begin
                    pos_stage_next = pos[PW-1:0];
                end
                state_next = cig_pkg::ST_OUT;
            end
            // hand result to output register
            cig_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = pos_stage_reg;
                    m_open_next  = mopen_reg;
                    state_next   = cig_pkg::ST_IDLE;
                end
            end
            default: state_next = cig_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg       <= 17'd19661;
            minp_reg        <= '0;
            maxp_reg        <= 18'd51905;
            segt_reg        <= 20'd33300;
            state_reg       <= cig_pkg::ST_IDLE;
            ret_reg         <= cig_pkg::ST_IDLE;
            load_cnt_reg    <= '0;
            bank_cnt0_reg   <= '0;
            bank_cnt1_reg   <= '0;
            active_reg      <= 1'b0;
            chunk_valid_reg <= 1'b0;
            stamp_reg       <= '0;
            filt_reg        <= '0;
            primed_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            alpha_reg       <= alpha_next;
            minp_reg        <= minp_next;
            maxp_reg        <= maxp_next;
            segt_reg        <= segt_next;
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            load_cnt_reg    <= load_cnt_next;
            bank_cnt0_reg   <= bank_cnt0_next;
            bank_cnt1_reg   <= bank_cnt1_next;
            active_reg      <= active_next;
            chunk_valid_reg <= chunk_valid_next;
            stamp_reg       <= stamp_next;
            filt_reg        <= filt_next;
            primed_reg      <= primed_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        meas_reg      <= meas_next;
        mopen_reg     <= mopen_next;
        seg_reg       <= seg_next;
        frac_reg      <= frac_next;
        o0_reg        <= o0_next;
        o1_reg        <= o1_next;
        s_reg         <= s_next;
        g_reg         <= g_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        pos_stage_reg <= pos_stage_next;
        m_pos_reg     <= m_pos_next;
        m_open_reg    <= m_open_next;
    end

    // sample memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/cig_div.sv */
// ----------------------------------------------------------------------------
// cig_div: iterative restoring divider
// One quotient bit per cycle; partial remainder preloaded so that a short
// quotient runs only as many steps as it has bits.
// ----------------------------------------------------------------------------
`default_nettype none
module cig_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  cig_pkg::div_req_t            req,
    output logic                         busy,
    output logic [cig_pkg::DQ_W-1:0]     quo,
    output logic [cig_pkg::DR_W-1:0]     rem
);

    logic                         busy_reg, busy_next;
    logic [cig_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [cig_pkg::DR_W-1:0]     rem_reg, rem_next;
    logic [cig_pkg::DQ_W-1:0]     quo_reg, quo_next;
    logic [cig_pkg::DR_W-1:0]     den_reg, den_next;
    logic [cig_pkg::DR_W:0]       trial;

    // one shift-subtract step
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[cig_pkg::DQ_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            quo_next  = req.quo_init;
            den_next  = req.den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = cig_pkg::DR_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[cig_pkg::DQ_W-2:0], 1'b1};
            end else begin
                rem_next = trial[cig_pkg::DR_W-1:0];
                quo_next = {quo_reg[cig_pkg::DQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cig_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* bench/chunk_interpolating_gripper_setpoint_checker.sv */
// ----------------------------------------------------------------------------
// chunk_interpolating_gripper_setpoint_checker: setpoint predictor and scoreboard
// Watches the config, input and result channels, keeps its own copy of the
// chunk banks, filter and registers, predicts each tick's result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none
module chunk_interpolating_gripper_setpoint_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [19:0] cfg_data,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire         s_operation,
    input  wire  [31:0] s_time_us,
    input  wire  [17:0] s_sample_value,
    input  wire         s_last_sample,
    input  wire  [17:0] s_measured_position,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [17:0] m_position_command,
    input  wire  [16:0] m_measured_openness,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        logic [17:0] position;
        logic [16:0] openness;
    } setpoint_t;

    // model state
    logic [16:0] bank_mem [cig_pkg::DEPTH];
    logic [6:0]  bank_len [2];
    logic [6:0]  fill_len;
    logic        live_bank;
    logic        have_chunk;
    logic [31:0] stamp;
    logic [16:0] filt;
    logic        primed;

    // register copy
    logic [16:0] alpha_q;
    logic [17:0] min_q;
    logic [17:0] max_q;
    logic [19:0] seg_us;

    setpoint_t expected_setpoints[$];

    function automatic logic [17:0] limit_position(logic [17:0] p);
        if (p < min_q) return min_q;
        if (p > max_q) return max_q;
        return p;
    endfunction

    function automatic logic [16:0] openness_of(logic [17:0] p);
        longint unsigned span, num, norm;
        if (max_q <= min_q) return cig_pkg::ONE_Q16;
        span = max_q - min_q;
        num  = limit_position(p) - min_q;
        norm = (num * 65536 + span / 2) / span;
        if (norm > 65536) norm = 65536;
        return 17'(65536 - norm);
    endfunction

    function automatic logic [17:0] position_of(logic [16:0] o);
        longint unsigned span, oo;
        span = 0;
        oo = (o > cig_pkg::ONE_Q16) ? 65536 : o;
        if (max_q > min_q) span = max_q - min_q;
        return 18'(min_q + (((65536 - oo) * span + 32768) >> 16));
    endfunction

    // linear interpolation across the live chunk
    function automatic logic [16:0] chunk_openness(logic [31:0] now);
        int unsigned base, n;
        longint unsigned dt, el, seg, frac, acc;
        logic [31:0] diff;
        base = live_bank * cig_pkg::MAX_SAMPLES;
        n    = bank_len[live_bank];
        dt   = (seg_us == 0) ? 1 : seg_us;
        if (n <= 1) return bank_mem[base];
        diff = now - stamp;
        el   = diff[31] ? 0 : diff;
        seg  = el / dt;
        if (seg >= n - 1) return bank_mem[base + n - 1];
        frac = el - seg * dt;
        acc  = bank_mem[base + seg] * (dt - frac) + bank_mem[base + seg + 1] * frac;
        return 17'((acc + dt / 2) / dt);
    endfunction

    // tick: update the filter and queue the expected setpoint
    task automatic predict_tick(logic [31:0] now, logic [17:0] meas);
        logic [16:0] s;
        longint unsigned f, diff, lo, g;
        setpoint_t sp;
        if (have_chunk && bank_len[live_bank] != 0) begin
            s = chunk_openness(now);
            if (!primed) begin
                filt = s;
                primed = 1'b1;
            end else begin
                f    = filt;
                diff = (s > f) ? s - f : f - s;
                lo   = (alpha_q > cig_pkg::ONE_Q16) ? 65536 : alpha_q;
                g    = diff * 5;
                if (g < lo) g = lo;
                if (g > 65536) g = 65536;
                filt = 17'((g * s + (65536 - g) * f + 32768) >> 16);
            end
        end else if (!primed) begin
            filt = openness_of(meas);
            primed = 1'b1;
        end
        sp.position = limit_position(position_of(filt));
        sp.openness = openness_of(meas);
        expected_setpoints.push_back(sp);
    endtask

    // sample load into the spare bank
    task automatic predict_load(logic [31:0] now, logic [17:0] raw, logic last);
        logic        spare;
        logic [16:0] v;
        spare = ~live_bank;
        if (raw[17]) v = '0;
        else v = (raw > 18'(cig_pkg::ONE_Q16)) ? cig_pkg::ONE_Q16 : raw[16:0];
        if (fill_len < cig_pkg::MAX_SAMPLES) begin
            bank_mem[spare * cig_pkg::MAX_SAMPLES + fill_len] = v;
            fill_len = fill_len + 1'b1;
        end
        if (last) begin
            bank_len[spare] = fill_len;
            live_bank  = spare;
            have_chunk = 1'b1;
            stamp      = now;
            fill_len   = '0;
        end
    endtask

    always @(posedge aclk) begin
        setpoint_t exp_sp;
        if (!aresetn) begin
            foreach (bank_mem[i]) bank_mem[i] = '0;
            bank_len[0] = '0;
            bank_len[1] = '0;
            fill_len   = '0;
            live_bank  = 1'b0;
            have_chunk = 1'b0;
            stamp      = '0;
            filt       = '0;
            primed     = 1'b0;
            alpha_q    = 17'd19661;
            min_q      = 18'd0;
            max_q      = 18'd51905;
            seg_us     = 20'd33300;
            fail_count   = 0;
            result_count = 0;
            expected_setpoints.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cig_pkg::reg_index_t'(cfg_index))
                    cig_pkg::REG_SMOOTH_ALPHA: alpha_q = cfg_data[16:0];
                    cig_pkg::REG_MIN_POSITION: min_q   = cfg_data[17:0];
                    cig_pkg::REG_MAX_POSITION: max_q   = cfg_data[17:0];
                    cig_pkg::REG_SEGMENT_TIME: seg_us  = cfg_data;
                    default: ;
                endcase
            end
            // accepted input item
            if (s_valid && s_ready) begin
                if (cig_pkg::op_t'(s_operation) == cig_pkg::OP_TICK)
                    predict_tick(s_time_us, s_measured_position);
                else
                    predict_load(s_time_us, s_sample_value, s_last_sample);
            end
            // accepted result item
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_setpoints.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result pos=%0d open=%0d", $time,
                             m_position_command, m_measured_openness);
                end else begin
                    exp_sp = expected_setpoints.pop_front();
                    if (m_position_command !== exp_sp.position) begin
                        fail_count++;
                        $display("%0t: position_command expected %0d actual %0d", $time,
                                 exp_sp.position, m_position_command);
                    end
                    if (m_measured_openness !== exp_sp.openness) begin
                        fail_count++;
                        $display("%0t: measured_openness expected %0d actual %0d", $time,
                                 exp_sp.openness, m_measured_openness);
                    end
                end
            end
        end
        pending_count = expected_setpoints.size();
    end

endmodule
`default_nettype wire

/* bench/chunk_interpolating_gripper_setpoint_tb.sv */
// ----------------------------------------------------------------------------
// chunk_interpolating_gripper_setpoint_tb: setpoint generator testbench
// Drives chunk loads and control ticks under several register settings with
// random gaps and stalls on both sides; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module chunk_interpolating_gripper_setpoint_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [31:0] s_time_us;
    logic signed [17:0] s_sample_value;
    logic        s_last_sample;
    logic [17:0] s_measured_position;
    logic        m_valid;
    logic        m_ready;
    logic [17:0] m_position_command;
    logic [16:0] m_measured_openness;

    int fail_count;
    int pending_count;
    int result_count;
    int items_sent;
    int idle_cycles;
    int recv_wait;
    int hold_left;
    bit hold_request;
    bit no_gaps;
    logic [19:0] seg_now;

    chunk_interpolating_gripper_setpoint uut (.*);

    chunk_interpolating_gripper_setpoint_checker checker_i (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog on stalled progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls per item, plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left = 400;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            recv_wait = no_gaps ? 0 : $urandom_range(0, 9);
    end

    // one input item; entered and left at a falling edge
    task automatic send_item(cig_pkg::op_t op, logic [31:0] t, logic [17:0] v,
                             logic last, logic [17:0] meas);
        int gap;
        bit rdy;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_operation         <= op;
        s_time_us           <= t;
        s_sample_value      <= v;
        s_last_sample       <= last;
        s_measured_position <= meas;
        forever begin
            #1 rdy = s_ready;
            @(posedge aclk);
            if (rdy) break;
            @(negedge aclk);
        end
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(cig_pkg::reg_index_t idx, logic [19:0] value);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            #1 rdy = cfg_ready;
            @(posedge aclk);
            if (rdy) break;
            @(negedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [19:0] alpha, logic [19:0] lo, logic [19:0] hi,
                            logic [19:0] seg);
        wait_drained();
        write_reg(cig_pkg::REG_SMOOTH_ALPHA, alpha);
        write_reg(cig_pkg::REG_MIN_POSITION, lo);
        write_reg(cig_pkg::REG_MAX_POSITION, hi);
        write_reg(cig_pkg::REG_SEGMENT_TIME, seg);
        seg_now = seg;
    endtask

    function automatic logic [17:0] rand_sample();
        if ($urandom_range(0, 4) == 0) return 18'($urandom);
        return 18'($urandom_range(0, 65536));
    endfunction

    // well-formed chunks followed by ticks, with some noise mixed in
    task automatic random_chunks(int n_items);
        int len, n_ticks, target;
        longint unsigned dt, span;
        logic [31:0] st, t;
        target = items_sent + n_items;
        while (items_sent < target) begin
            dt  = (seg_now == 0) ? 1 : seg_now;
            len = ($urandom_range(0, 40) == 0) ? $urandom_range(64, 70)
                                                : $urandom_range(1, 6);
            st  = $urandom;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(cig_pkg::OP_TICK, $urandom, rand_sample(), 1'($urandom),
                              18'($urandom));
                send_item(cig_pkg::OP_LOAD, st, rand_sample(), i == len - 1,
                          18'($urandom));
            end
            n_ticks = $urandom_range(1, 6);
            span = dt * (len + 1);
            if (span > 32'h7fff_ffff) span = 32'h7fff_ffff;
            for (int k = 0; k < n_ticks; k++) begin
                case ($urandom_range(0, 19))
                    0:       t = st - $urandom_range(1, 1000);
                    1:       t = $urandom;
                    default: t = st + 32'($urandom_range(0, 32'(span)));
                endcase
                send_item(cig_pkg::OP_TICK, t, 18'($urandom), 1'($urandom),
                          18'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid = 1'b0;
        s_operation = cig_pkg::OP_LOAD;
        s_time_us = '0;
        s_sample_value = '0;
        s_last_sample = 1'b0;
        s_measured_position = '0;
        items_sent = 0;
        idle_cycles = 0;
        recv_wait = 0;
        hold_left = 0;
        hold_request = 0;
        no_gaps = 0;
        seg_now = 20'd33300;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: ticks before any chunk seed and then hold the filter
        send_item(cig_pkg::OP_TICK, 32'd100, '0, 1'b0, 18'd20000);
        send_item(cig_pkg::OP_TICK, 32'd200, '0, 1'b0, 18'h3ffff);
        send_item(cig_pkg::OP_TICK, 32'd300, '0, 1'b0, 18'd0);
        // extreme samples, clamped on load
        send_item(cig_pkg::OP_LOAD, 32'd1000, 18'h20000, 1'b0, '0);
        send_item(cig_pkg::OP_LOAD, 32'd1000, 18'h1ffff, 1'b0, '0);
        send_item(cig_pkg::OP_LOAD, 32'd1000, 18'd65536, 1'b0, '0);
        send_item(cig_pkg::OP_LOAD, 32'd1000, 18'd0, 1'b0, '0);
        send_item(cig_pkg::OP_LOAD, 32'hffff_fff0, 18'd32768, 1'b1, '0);
        // ticks before the stamp, at it, mid segment, past the end, wrapped
        send_item(cig_pkg::OP_TICK, 32'hffff_ff00, '0, 1'b0, 18'd51905);
        send_item(cig_pkg::OP_TICK, 32'hffff_fff0, '0, 1'b0, 18'd100000);
        send_item(cig_pkg::OP_TICK, 32'd16000, '0, 1'b0, 18'd25000);
        send_item(cig_pkg::OP_TICK, 32'd50000, '0, 1'b0, 18'd1);
        send_item(cig_pkg::OP_TICK, 32'd5000000, '0, 1'b0, 18'd51904);
        // single sample chunk
        send_item(cig_pkg::OP_LOAD, 32'd7, 18'd12345, 1'b1, '0);
        send_item(cig_pkg::OP_TICK, 32'd9, '0, 1'b0, 18'd30000);
        send_item(cig_pkg::OP_TICK, 32'd90000, '0, 1'b0, 18'd30000);

        random_chunks(70);

        // receiver holds off while items keep coming
        hold_request = 1;
        random_chunks(30);
        // sender waits for every result before going on
        wait_drained();
        random_chunks(20);

        // full range, minimum gain, one microsecond segments
        set_regs(20'd0, 20'd0, 20'h3ffff, 20'd1);
        random_chunks(70);
        // unity gain, narrow span, no gaps on either side
        set_regs(20'd65536, 20'd1000, 20'd60000, 20'd50);
        no_gaps = 1;
        random_chunks(70);
        no_gaps = 0;
        // gain above one, inverted limits, zero segment time
        set_regs(20'h1ffff, 20'd50000, 20'd20000, 20'd0);
        random_chunks(60);
        // equal limits, longest segments
        set_regs(20'd19661, 20'd40000, 20'd40000, 20'hfffff);
        random_chunks(60);
        // back to typical values, slow segments
        set_regs(20'd30000, 20'd5000, 20'd51905, 20'd1000000);
        random_chunks(50);
        // limits at the top of the position range, gain just below one, short segments
        set_regs(20'd65535, 20'h3fffe, 20'h3ffff, 20'd7);
        random_chunks(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("sent %0d items over seven register settings, checked %0d results",
                 items_sent, result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
design/cig_pkg.sv
design/cig_div.sv
design/chunk_interpolating_gripper_setpoint.sv
bench/chunk_interpolating_gripper_setpoint_checker.sv
bench/chunk_interpolating_gripper_setpoint_tb.sv
